[hdl/ecng_pkg.sv]
// shared types, widths and trig polynomial helpers for the contour node generator
`timescale 1ns / 1ps
package ecng_pkg;

	localparam int IDX_W  = 6;
	localparam int POS_W  = 20;
	localparam int RAD_W  = 16;
	localparam int TRIG_W = 31;
	localparam int VX_W   = 30;
	localparam int SUM_W  = 61;
	localparam int SQ_W   = 31;
	localparam int NUM_W  = 45;
	localparam int Q_W    = 15;
	localparam int NRM_W  = 16;
	localparam int PROD_W = 47;
	localparam int OFF_W  = 17;
	localparam int EXT_W  = 22;

	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
	localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
	localparam logic [63:0] QUARTER    = 64'd1 << 22;
	localparam logic [63:0] EIGHTH     = 64'd1 << 21;
	localparam logic signed [EXT_W-1:0] POS_MAX = 22'sd524287;
	localparam logic signed [EXT_W-1:0] POS_MIN = -22'sd524288;

	typedef struct packed {
		logic              cneg;
		logic              sneg;
		logic [TRIG_W-1:0] cm;
		logic [TRIG_W-1:0] sm;
	} trig_t;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic                    last;
		trig_t                   trig;
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic [RAD_W-1:0]        major;
		logic [RAD_W-1:0]        minor;
		logic [RAD_W-1:0]        ma;
		logic [RAD_W-1:0]        mi;
	} issue_t;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic                    last;
		logic                    cneg;
		logic                    sneg;
		logic [TRIG_W-1:0]       cm;
		logic [TRIG_W-1:0]       sm;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} node_side_t;

	typedef struct packed {
		node_side_t       node;
		logic [VX_W-1:0]  vx;
		logic [VX_W-1:0]  vy;
	} sq_side_t;

	function automatic logic [63:0] sin_oct(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		return (x * t) >> 30;
	endfunction

	function automatic logic [63:0] cos_oct(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
		return t;
	endfunction

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v > POS_MAX) r = POS_MAX[POS_W-1:0];
		else if (v < POS_MIN) r = POS_MIN[POS_W-1:0];
		else r = v[POS_W-1:0];
		return r;
	endfunction

endpackage

[hdl/ecng_issue.sv]
// ellipse intake, radius normalisation and per-node issue with trig table lookup
`timescale 1ns / 1ps
module ecng_issue #(
	parameter int NODES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               s_valid,
	output logic                               s_ready,
	input  logic signed [ecng_pkg::POS_W-1:0]  center_x,
	input  logic signed [ecng_pkg::POS_W-1:0]  center_y,
	input  logic [ecng_pkg::RAD_W-1:0]         major_radius,
	input  logic [ecng_pkg::RAD_W-1:0]         minor_radius,
	output logic                               issue_valid_s1,
	output ecng_pkg::issue_t                   issue_s1
);

	localparam int TAB_N = 2 ** ecng_pkg::IDX_W;

	function automatic ecng_pkg::trig_t trig_entry(input int unsigned i);
		logic [63:0] ph;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] c;
		logic [63:0] s;
		ecng_pkg::trig_t e;
		ph = ((64'(i) << 24) + 64'(NODES / 2)) / NODES;
		ph = ph & 64'hFF_FFFF;
		r = ph & (ecng_pkg::QUARTER - 64'd1);
		if (r <= ecng_pkg::EIGHTH) begin
			x = (r * ecng_pkg::TWO_PI_Q32) >> 26;
			c = ecng_pkg::cos_oct(x);
			s = ecng_pkg::sin_oct(x);
		end else begin
			x = ((ecng_pkg::QUARTER - r) * ecng_pkg::TWO_PI_Q32) >> 26;
			c = ecng_pkg::sin_oct(x);
			s = ecng_pkg::cos_oct(x);
		end
		case (ph[23:22])
			2'd0: begin
				e.cm = c[30:0]; e.cneg = 1'b0; e.sm = s[30:0]; e.sneg = 1'b0;
			end
			2'd1: begin
				e.cm = s[30:0]; e.cneg = 1'b1; e.sm = c[30:0]; e.sneg = 1'b0;
			end
			2'd2: begin
				e.cm = c[30:0]; e.cneg = 1'b1; e.sm = s[30:0]; e.sneg = 1'b1;
			end
			default: begin
				e.cm = s[30:0]; e.cneg = 1'b0; e.sm = c[30:0]; e.sneg = 1'b1;
			end
		endcase
		return e;
	endfunction

	ecng_pkg::trig_t trig_tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		if (g < NODES) begin : g_used
			localparam ecng_pkg::trig_t ENT = trig_entry(g);
			assign trig_tab[g] = ENT;
		end else begin : g_unused
			assign trig_tab[g] = '0;
		end
	end

	logic                              busy_q;
	logic [ecng_pkg::IDX_W-1:0]        cnt_q;
	logic signed [ecng_pkg::POS_W-1:0] cx_q;
	logic signed [ecng_pkg::POS_W-1:0] cy_q;
	logic [ecng_pkg::RAD_W-1:0]        maj_q;
	logic [ecng_pkg::RAD_W-1:0]        min_q;
	logic [ecng_pkg::RAD_W-1:0]        ma_q;
	logic [ecng_pkg::RAD_W-1:0]        mi_q;

	logic                       last_issue;
	logic                       accept;
	logic [ecng_pkg::RAD_W-1:0] maj1;
	logic [ecng_pkg::RAD_W-1:0] min1;
	logic [ecng_pkg::RAD_W-1:0] orv;
	logic [3:0]                 msb;
	logic [3:0]                 sh;

	assign last_issue = busy_q && (cnt_q == ecng_pkg::IDX_W'(NODES - 1));
	assign s_ready    = en && (!busy_q || last_issue);
	assign accept     = s_valid && s_ready;

	// zero radius counts as one lsb; shift both until the larger has its top bit set
	always_comb begin
		maj1 = (major_radius == '0) ? 16'd1 : major_radius;
		min1 = (minor_radius == '0) ? 16'd1 : minor_radius;
		orv  = maj1 | min1;
		msb  = 4'd0;
		for (int k = 0; k < ecng_pkg::RAD_W; k++) begin
			if (orv[k]) msb = 4'(k);
		end
		sh = 4'd15 - msb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			cnt_q          <= '0;
			issue_valid_s1 <= 1'b0;
		end else if (en) begin
			issue_valid_s1 <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last_issue) busy_q <= 1'b0;
				else cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			issue_s1.idx   <= cnt_q;
			issue_s1.last  <= last_issue;
			issue_s1.trig  <= trig_tab[cnt_q];
			issue_s1.cx    <= cx_q;
			issue_s1.cy    <= cy_q;
			issue_s1.major <= maj_q;
			issue_s1.minor <= min_q;
			issue_s1.ma    <= ma_q;
			issue_s1.mi    <= mi_q;
		end
		if (accept) begin
			cx_q  <= center_x;
			cy_q  <= center_y;
			maj_q <= maj1;
			min_q <= min1;
			ma_q  <= maj1 << sh;
			mi_q  <= min1 << sh;
		end
	end

endmodule

[hdl/ecng_sqrt.sv]
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module ecng_sqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [ecng_pkg::SUM_W-1:0]   in_value,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [ecng_pkg::SQ_W-1:0]    out_root,
	output logic [SIDE_W-1:0]            out_side
);

	localparam int RW = ecng_pkg::SQ_W;
	localparam int VW = ecng_pkg::SUM_W;
	localparam int CW = VW + 2;

	logic          valid_s [RW+1];
	logic [VW-1:0] rem_s   [RW+1];
	logic [RW-1:0] root_s  [RW+1];
	logic [SIDE_W-1:0] side_s [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else if (en) valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= in_value;
			root_s[0] <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar j = 0; j < RW; j++) begin : g_stage
		localparam int K = RW - 1 - j;
		logic [CW-1:0] inc;
		logic [CW-1:0] rem_e;
		logic [VW-1:0] rem_n;
		logic [RW-1:0] root_n;

		// (root + 2^k)^2 - root^2 against what is left of the radicand
		always_comb begin
			inc   = (CW'(root_s[j]) << (K + 1)) + (CW'(1) << (2 * K));
			rem_e = CW'(rem_s[j]);
			if (rem_e >= inc) begin
				rem_n  = VW'(rem_e - inc);
				root_n = root_s[j] | (RW'(1) << K);
			end else begin
				rem_n  = rem_s[j];
				root_n = root_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[j+1] <= 1'b0;
			else if (en) valid_s[j+1] <= valid_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= rem_n;
				root_s[j+1] <= root_n;
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = valid_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

[hdl/ecng_div.sv]
// dual pipelined restoring divider sharing one divisor, one quotient bit per stage
`timescale 1ns / 1ps
module ecng_div #(
	parameter int SIDE_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ecng_pkg::NUM_W-1:0]  num_x,
	input  logic [ecng_pkg::NUM_W-1:0]  num_y,
	input  logic [ecng_pkg::SQ_W-1:0]   den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [ecng_pkg::Q_W-1:0]    quot_x,
	output logic [ecng_pkg::Q_W-1:0]    quot_y,
	output logic [SIDE_W-1:0]           out_side
);

	localparam int QW = ecng_pkg::Q_W;
	localparam int NW = ecng_pkg::NUM_W;
	localparam int DW = ecng_pkg::SQ_W;
	localparam int CW = NW + 1;

	logic          valid_s [QW+1];
	logic [NW-1:0] rx_s    [QW+1];
	logic [NW-1:0] ry_s    [QW+1];
	logic [QW-1:0] qx_s    [QW+1];
	logic [QW-1:0] qy_s    [QW+1];
	logic [DW-1:0] d_s     [QW+1];
	logic [SIDE_W-1:0] side_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else if (en) valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]   <= num_x;
			ry_s[0]   <= num_y;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			d_s[0]    <= den;
			side_s[0] <= in_side;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [CW-1:0] dk;
		logic [NW-1:0] rx_n;
		logic [NW-1:0] ry_n;
		logic [QW-1:0] qx_n;
		logic [QW-1:0] qy_n;

		always_comb begin
			dk   = CW'(d_s[j]) << K;
			rx_n = rx_s[j];
			ry_n = ry_s[j];
			qx_n = qx_s[j];
			qy_n = qy_s[j];
			if (CW'(rx_s[j]) >= dk) begin
				rx_n = NW'(CW'(rx_s[j]) - dk);
				qx_n = qx_s[j] | (QW'(1) << K);
			end
			if (CW'(ry_s[j]) >= dk) begin
				ry_n = NW'(CW'(ry_s[j]) - dk);
				qy_n = qy_s[j] | (QW'(1) << K);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[j+1] <= 1'b0;
			else if (en) valid_s[j+1] <= valid_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[j+1]   <= rx_n;
				ry_s[j+1]   <= ry_n;
				qx_s[j+1]   <= qx_n;
				qy_s[j+1]   <= qy_n;
				d_s[j+1]    <= d_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign quot_x    = qx_s[QW];
	assign quot_y    = qy_s[QW];
	assign out_side  = side_s[QW];

endmodule

[hdl/ellipse_contour_node_generator.sv]
// top level: ellipse in, NODES contour nodes with normals and measurement terms out
//
// channel   direction  role                     tdata fields (lsb up)
// s_axis    in         ellipse per transaction  center_x, center_y, major_radius, minor_radius
// m_axis    out        one node per transaction node_index .. meas_minor_term, tlast = last_node
//
// one node leaves per cycle while m_axis is not stalled; the next ellipse is taken
// in the cycle its predecessor issues its final node
// a node passes 3 front stages, the square root stages (one root bit each), the divider
// stages (one quotient bit each) and the output register
// reset clears the issue counter and all stage valid bits
// a stall on m_axis freezes every stage at once; nothing is dropped or repeated
`timescale 1ns / 1ps
module ellipse_contour_node_generator #(
	parameter int NODES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_x[19:0], center_y[39:20], major_radius[55:40], minor_radius[71:56]
	input  logic [71:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// node_index[5:0], pos_x[25:6], pos_y[45:26], normal_x[61:46], normal_y[77:62],
	// meas_major_term[93:78], meas_minor_term[109:94], zero fill[111:110]
	output logic [111:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int PW = ecng_pkg::PROD_W;
	localparam int VXW = ecng_pkg::VX_W;
	localparam int NW = ecng_pkg::NUM_W;
	localparam int SQW = ecng_pkg::SQ_W;
	localparam int QW = ecng_pkg::Q_W;
	localparam int NRW = ecng_pkg::NRM_W;
	localparam int SQ_SIDE_W = $bits(ecng_pkg::sq_side_t);
	localparam int DV_SIDE_W = $bits(ecng_pkg::node_side_t);

	logic en;
	logic issue_valid_s1;
	ecng_pkg::issue_t issue_s1;

	logic        out_valid_q;
	logic [111:0] out_data_q;
	logic        out_last_q;

	assign en = !out_valid_q || m_axis_tready;

	ecng_issue #(.NODES(NODES)) u_issue (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.s_valid        (s_axis_tvalid),
		.s_ready        (s_axis_tready),
		.center_x       (s_axis_tdata[19:0]),
		.center_y       (s_axis_tdata[39:20]),
		.major_radius   (s_axis_tdata[55:40]),
		.minor_radius   (s_axis_tdata[71:56]),
		.issue_valid_s1 (issue_valid_s1),
		.issue_s1       (issue_s1)
	);

	// stage 2: the four radius by trig products
	logic          valid_s2;
	logic [VXW-1:0] vx_s2;
	logic [VXW-1:0] vy_s2;
	logic [PW-1:0] offx_s2;
	logic [PW-1:0] offy_s2;
	ecng_pkg::issue_t info_s2;
	logic [PW-1:0] pvx;
	logic [PW-1:0] pvy;

	assign pvx = PW'(issue_s1.mi) * PW'(issue_s1.trig.cm);
	assign pvy = PW'(issue_s1.ma) * PW'(issue_s1.trig.sm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= issue_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s2   <= pvx[VXW+15:16];
			vy_s2   <= pvy[VXW+15:16];
			offx_s2 <= PW'(issue_s1.major) * PW'(issue_s1.trig.cm);
			offy_s2 <= PW'(issue_s1.minor) * PW'(issue_s1.trig.sm);
			info_s2 <= issue_s1;
		end
	end

	// stage 3: positions, and the squares for the normal length
	logic           valid_s3;
	logic [2*VXW-1:0] vx2_s3;
	logic [2*VXW-1:0] vy2_s3;
	ecng_pkg::sq_side_t side_s3;
	logic [PW:0]    rx;
	logic [PW:0]    ry;
	logic signed [ecng_pkg::EXT_W-1:0] cxe;
	logic signed [ecng_pkg::EXT_W-1:0] cye;
	logic signed [ecng_pkg::EXT_W-1:0] ox;
	logic signed [ecng_pkg::EXT_W-1:0] oy;

	// offsets rounded half away from zero, then applied with the trig sign
	always_comb begin
		rx  = (PW + 1)'(offx_s2) + ((PW + 1)'(1) << 29);
		ry  = (PW + 1)'(offy_s2) + ((PW + 1)'(1) << 29);
		cxe = ecng_pkg::EXT_W'(info_s2.cx);
		cye = ecng_pkg::EXT_W'(info_s2.cy);
		ox  = $signed(ecng_pkg::EXT_W'(rx[29+ecng_pkg::OFF_W:30]));
		oy  = $signed(ecng_pkg::EXT_W'(ry[29+ecng_pkg::OFF_W:30]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx2_s3 <= (2 * VXW)'(vx_s2) * (2 * VXW)'(vx_s2);
			vy2_s3 <= (2 * VXW)'(vy_s2) * (2 * VXW)'(vy_s2);
			side_s3.vx <= vx_s2;
			side_s3.vy <= vy_s2;
			side_s3.node.idx  <= info_s2.idx;
			side_s3.node.last <= info_s2.last;
			side_s3.node.cneg <= info_s2.trig.cneg;
			side_s3.node.sneg <= info_s2.trig.sneg;
			side_s3.node.cm   <= info_s2.trig.cm;
			side_s3.node.sm   <= info_s2.trig.sm;
			side_s3.node.pos_x <= ecng_pkg::sat_pos(info_s2.trig.cneg ? cxe - ox : cxe + ox);
			side_s3.node.pos_y <= ecng_pkg::sat_pos(info_s2.trig.sneg ? cye - oy : cye + oy);
		end
	end

	logic                        sq_valid;
	logic [SQW-1:0]              sq_root;
	logic [SQ_SIDE_W-1:0]        sq_side_raw;
	ecng_pkg::sq_side_t          sq_side;

	ecng_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_value  (ecng_pkg::SUM_W'(vx2_s3) + ecng_pkg::SUM_W'(vy2_s3)),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side_raw)
	);

	assign sq_side = sq_side_raw;

	logic [SQW-1:0] len;
	logic [NW-1:0]  nx;
	logic [NW-1:0]  ny;

	// a zero length is taken as one; numerators carry the half for rounding
	always_comb begin
		len = (sq_root == '0) ? SQW'(1) : sq_root;
		nx  = (NW'(sq_side.vx) << 14) + NW'(len >> 1);
		ny  = (NW'(sq_side.vy) << 14) + NW'(len >> 1);
	end

	logic                 dv_valid;
	logic [QW-1:0]        qx;
	logic [QW-1:0]        qy;
	logic [DV_SIDE_W-1:0] dv_side_raw;
	ecng_pkg::node_side_t dv_side;

	ecng_div #(.SIDE_W(DV_SIDE_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.num_x     (nx),
		.num_y     (ny),
		.den       (len),
		.in_side   (sq_side.node),
		.out_valid (dv_valid),
		.quot_x    (qx),
		.quot_y    (qy),
		.out_side  (dv_side_raw)
	);

	assign dv_side = dv_side_raw;

	// output stage: measurement terms and signed normals
	localparam int TW = 46;
	logic [TW-1:0]  tx_w;
	logic [TW-1:0]  ty_w;
	logic [NRW-1:0] nxv;
	logic [NRW-1:0] nyv;

	always_comb begin
		tx_w = TW'(qx) * TW'(dv_side.cm) + (TW'(1) << 29);
		ty_w = TW'(qy) * TW'(dv_side.sm) + (TW'(1) << 29);
		nxv  = dv_side.cneg ? NRW'(-NRW'(qx)) : NRW'(qx);
		nyv  = dv_side.sneg ? NRW'(-NRW'(qy)) : NRW'(qy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {2'b00, ty_w[45:30], tx_w[45:30], nyv, nxv,
				dv_side.pos_y, dv_side.pos_x, dv_side.idx};
			out_last_q <= dv_side.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

[hdl/ecng_checker.sv]
// port-level checks on node order and output stall behaviour, bound to the top level
`timescale 1ns / 1ps
module ecng_checker #(
	parameter int NODES = 16
) (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [111:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	logic       out_acc;
	logic [5:0] exp_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) exp_q <= '0;
		else if (out_acc) exp_q <= m_axis_tlast ? 6'd0 : exp_q + 6'd1;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> m_axis_tdata[5:0] == exp_q)
		else $error("node index out of sequence");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> m_axis_tlast == (m_axis_tdata[5:0] == 6'(NODES - 1)))
		else $error("tlast not on final node");

endmodule

bind ellipse_contour_node_generator ecng_checker #(.NODES(NODES)) u_ecng_checker (.*);
